// ----- hdl/rotation_matrix_to_quaternion_assert.svh -----
// Assertion macros shared by the quaternion conversion modules.
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// Same-cycle implication, sampled on clock and switched off during reset.
`define RMQ_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rmq same-cycle check failed");

// Next-cycle implication, sampled on clock and switched off during reset.
`define RMQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rmq next-cycle check failed");

`endif

// ----- hdl/rmq_pkg.sv -----
package rmq_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 14;
   localparam int LANES      = 3;

   localparam int SUM_W  = DATA_WIDTH + 3;
   localparam int ROOT_W = (DATA_WIDTH + FRAC_BITS) / 2;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 4;
   localparam int MAG_W  = DATA_WIDTH + 1;
   localparam int DIV_W  = ROOT_W + 2;
   localparam int NUM_W  = MAG_W + FRAC_BITS;
   localparam int Q_W    = NUM_W - (FRAC_BITS / 2 + 1);
   localparam int DREM_W = DIV_W + 1;

   localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(1 << FRAC_BITS);
   localparam logic [ROOT_W-1:0] MIN_ROOT = ROOT_W'(1 << ((FRAC_BITS - 2) / 2));
   localparam logic [Q_W-1:0] POS_LIM = Q_W'((1 << (DATA_WIDTH - 1)) - 1);
   localparam logic [Q_W-1:0] NEG_LIM = Q_W'(1 << (DATA_WIDTH - 1));

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic [MAG_W-1:0] mag_type;

   // Which component comes from the square root.
   typedef enum logic [3:0] {
      SEL_X = 4'b0001,
      SEL_Y = 4'b0010,
      SEL_Z = 4'b0100,
      SEL_W = 4'b1000
   } sel_type;

   typedef struct packed {
      logic                   bad;
      sel_type                sel;
      logic [LANES-1:0]       neg;
      mag_type [LANES-1:0]    mag;
   } root_side_type;

   typedef struct packed {
      logic                   bad;
      sel_type                sel;
      logic [LANES-1:0]       neg;
      logic [ROOT_W-1:0]      root;
   } div_side_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
   } sq_step_type;

   typedef struct packed {
      logic [DREM_W-1:0] rem;
      logic [Q_W-1:0]    quo;
      logic [Q_W-1:0]    num;
   } dv_step_type;

   // One result bit of the digit-by-digit integer square root.
   function automatic sq_step_type sqrt_step(input sq_step_type s);
      logic [REM_W-1:0] cur;
      logic [REM_W-1:0] trial;
      sq_step_type      r;
      cur   = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
      trial = REM_W'({s.root, 2'b01});
      r.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (cur >= trial) begin
         r.rem  = cur - trial;
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = cur;
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // One quotient bit of a restoring unsigned division.
   function automatic dv_step_type div_step(input dv_step_type s,
                                            input logic [DIV_W-1:0] dvs);
      logic [DREM_W-1:0] cur;
      dv_step_type       r;
      cur   = {s.rem[DREM_W-2:0], s.num[Q_W-1]};
      r.num = {s.num[Q_W-2:0], 1'b0};
      if (cur >= DREM_W'(dvs)) begin
         r.rem = cur - DREM_W'(dvs);
         r.quo = {s.quo[Q_W-2:0], 1'b1};
      end else begin
         r.rem = cur;
         r.quo = {s.quo[Q_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // Signed saturation of a sign and magnitude quotient.
   function automatic data_type sat_mag(input logic neg, input logic [Q_W-1:0] mag);
      logic [Q_W-1:0] tmp;
      data_type       r;
      tmp = Q_W'(0) - mag;
      if (neg) begin
         if (mag >= NEG_LIM) begin
            r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
         end else begin
            r = tmp[DATA_WIDTH-1:0];
         end
      end else begin
         if (mag > POS_LIM) begin
            r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
         end else begin
            r = mag[DATA_WIDTH-1:0];
         end
      end
      return r;
   endfunction

endpackage

// ----- hdl/rotation_matrix_to_quaternion.sv -----
// Converts a 3x3 rotation matrix in signed Q2.14 into a unit quaternion (w,x,y,z)
// in Q2.14, picking the root component Shepperd style: w when the trace is
// non-negative, else the largest diagonal element (lower index on ties). The block
// is a fixed pipeline of 40 register stages: one for the branch choice, 15 for the
// bit-per-stage square root, 23 for the three parallel bit-per-stage dividers and
// one output register. It takes one matrix every cycle while the pipeline moves;
// while rsp_valid is high and rsp_ready low the whole pipeline holds and req_ready
// is low. A matrix whose root argument is not positive comes back with
// rsp_bad_matrix set and all four components zero.
`include "rotation_matrix_to_quaternion_assert.svh"

module rotation_matrix_to_quaternion (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rmq_pkg::data_type req_m00,
   input  rmq_pkg::data_type req_m01,
   input  rmq_pkg::data_type req_m02,
   input  rmq_pkg::data_type req_m10,
   input  rmq_pkg::data_type req_m11,
   input  rmq_pkg::data_type req_m12,
   input  rmq_pkg::data_type req_m20,
   input  rmq_pkg::data_type req_m21,
   input  rmq_pkg::data_type req_m22,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rmq_pkg::data_type rsp_q_w,
   output rmq_pkg::data_type rsp_q_x,
   output rmq_pkg::data_type rsp_q_y,
   output rmq_pkg::data_type rsp_q_z,
   output logic              rsp_bad_matrix
);
   import rmq_pkg::*;

   logic                    advance;
   logic signed [SUM_W-1:0] trace;
   logic signed [SUM_W-1:0] arg;
   sel_type                 sel;
   logic                    bad;
   logic signed [MAG_W-1:0] diff [LANES];
   root_side_type           side_in;
   logic [RAD_W-1:0]        rad_in;

   logic                    s0_valid_ff;
   logic [RAD_W-1:0]        s0_rad_ff;
   root_side_type           s0_side_ff;

   logic                    sq_valid;
   logic [ROOT_W-1:0]       sq_root;
   root_side_type           sq_side;
   div_side_type            dv_side_in;

   logic                    dv_valid;
   logic [LANES-1:0][Q_W-1:0] dv_quo;
   div_side_type            dv_side;

   data_type                root_c;
   data_type                comp [LANES];
   data_type                q_w_in, q_x_in, q_y_in, q_z_in;

   logic                    rsp_valid_ff;
   data_type                q_w_ff, q_x_ff, q_y_ff, q_z_ff;
   logic                    bad_ff;

   // The whole pipeline moves unless a finished word is waiting at the output.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      trace = SUM_W'(req_m00) + SUM_W'(req_m11) + SUM_W'(req_m22);
      sel   = SEL_X;
      if (req_m11 > req_m00) begin
         sel = SEL_Y;
      end
      if (req_m22 > ((sel == SEL_Y) ? req_m11 : req_m00)) begin
         sel = SEL_Z;
      end
      if (!trace[SUM_W-1]) begin
         sel = SEL_W;
      end

      case (sel)
         SEL_W: begin
            arg     = trace + ONE_S;
            diff[0] = MAG_W'(req_m21) - MAG_W'(req_m12);
            diff[1] = MAG_W'(req_m02) - MAG_W'(req_m20);
            diff[2] = MAG_W'(req_m10) - MAG_W'(req_m01);
         end
         SEL_X: begin
            arg     = SUM_W'(req_m00) - SUM_W'(req_m11) - SUM_W'(req_m22) + ONE_S;
            diff[0] = MAG_W'(req_m10) + MAG_W'(req_m01);
            diff[1] = MAG_W'(req_m20) + MAG_W'(req_m02);
            diff[2] = MAG_W'(req_m21) - MAG_W'(req_m12);
         end
         SEL_Y: begin
            arg     = SUM_W'(req_m11) - SUM_W'(req_m22) - SUM_W'(req_m00) + ONE_S;
            diff[0] = MAG_W'(req_m21) + MAG_W'(req_m12);
            diff[1] = MAG_W'(req_m01) + MAG_W'(req_m10);
            diff[2] = MAG_W'(req_m02) - MAG_W'(req_m20);
         end
         SEL_Z: begin
            arg     = SUM_W'(req_m22) - SUM_W'(req_m00) - SUM_W'(req_m11) + ONE_S;
            diff[0] = MAG_W'(req_m02) + MAG_W'(req_m20);
            diff[1] = MAG_W'(req_m12) + MAG_W'(req_m21);
            diff[2] = MAG_W'(req_m10) - MAG_W'(req_m01);
         end
         default: begin
            arg     = '0;
            diff[0] = '0;
            diff[1] = '0;
            diff[2] = '0;
         end
      endcase

      bad = arg[SUM_W-1] || (arg == '0);
      if (bad) begin
         rad_in = '0;
      end else begin
         rad_in = RAD_W'({arg[DATA_WIDTH:0], {(FRAC_BITS-2){1'b0}}});
      end

      side_in.bad = bad;
      side_in.sel = sel;
      for (int l = 0; l < LANES; l++) begin
         side_in.neg[l] = diff[l][MAG_W-1];
         side_in.mag[l] = diff[l][MAG_W-1] ? MAG_W'(-diff[l]) : MAG_W'(diff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_rad_ff  <= rad_in;
         s0_side_ff <= side_in;
      end
   end

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s0_valid_ff),
      .in_rad    (s0_rad_ff),
      .in_side   (s0_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   always_comb begin
      dv_side_in.bad  = sq_side.bad;
      dv_side_in.sel  = sq_side.sel;
      dv_side_in.neg  = sq_side.neg;
      dv_side_in.root = sq_root;
   end

   rmq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sq_valid),
      .in_mag    (sq_side.mag),
      .in_side   (dv_side_in),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   always_comb begin
      root_c = {{(DATA_WIDTH-ROOT_W){1'b0}}, dv_side.root};
      for (int l = 0; l < LANES; l++) begin
         comp[l] = sat_mag(dv_side.neg[l], dv_quo[l]);
      end
      case (dv_side.sel)
         SEL_W: begin
            q_w_in = root_c;  q_x_in = comp[0]; q_y_in = comp[1]; q_z_in = comp[2];
         end
         SEL_X: begin
            q_x_in = root_c;  q_y_in = comp[0]; q_z_in = comp[1]; q_w_in = comp[2];
         end
         SEL_Y: begin
            q_y_in = root_c;  q_z_in = comp[0]; q_x_in = comp[1]; q_w_in = comp[2];
         end
         SEL_Z: begin
            q_z_in = root_c;  q_x_in = comp[0]; q_y_in = comp[1]; q_w_in = comp[2];
         end
         default: begin
            q_w_in = '0;      q_x_in = '0;      q_y_in = '0;      q_z_in = '0;
         end
      endcase
      if (dv_side.bad) begin
         q_w_in = '0;
         q_x_in = '0;
         q_y_in = '0;
         q_z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q_w_ff <= q_w_in;
         q_x_ff <= q_x_in;
         q_y_ff <= q_y_in;
         q_z_ff <= q_z_in;
         bad_ff <= dv_side.bad;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_q_w        = q_w_ff;
   assign rsp_q_x        = q_x_ff;
   assign rsp_q_y        = q_y_ff;
   assign rsp_q_z        = q_z_ff;
   assign rsp_bad_matrix = bad_ff;

   `RMQ_ASSERT_IMPL(a_bad_is_zero, rsp_valid_ff && bad_ff,
      (q_w_ff == '0) && (q_x_ff == '0) && (q_y_ff == '0) && (q_z_ff == '0))
   // The root component of a good result is never zero.
   `RMQ_ASSERT_IMPL(a_good_not_zero, rsp_valid_ff && !bad_ff,
      (q_w_ff != '0) || (q_x_ff != '0) || (q_y_ff != '0) || (q_z_ff != '0))
   // A stall must freeze the entry stage as well as the output.
   `RMQ_ASSERT_NEXT(a_entry_holds, s0_valid_ff && !advance,
      s0_valid_ff && $stable(s0_rad_ff) && $stable(s0_side_ff))

endmodule

// ----- hdl/rmq_sqrt.sv -----
`include "rotation_matrix_to_quaternion_assert.svh"

module rmq_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [rmq_pkg::RAD_W-1:0]     in_rad,
   input  rmq_pkg::root_side_type        in_side,
   output logic                          out_valid,
   output logic [rmq_pkg::ROOT_W-1:0]    out_root,
   output rmq_pkg::root_side_type        out_side
);
   import rmq_pkg::*;

   logic [ROOT_W-1:0] valid_ff;
   sq_step_type       step_ff [ROOT_W];
   sq_step_type       step_in [ROOT_W];
   sq_step_type       prev    [ROOT_W];
   root_side_type     side_ff [ROOT_W];

   always_comb begin
      prev[0].rem  = '0;
      prev[0].root = '0;
      prev[0].rad  = in_rad;
      for (int k = 1; k < ROOT_W; k++) begin
         prev[k] = step_ff[k-1];
      end
      for (int k = 0; k < ROOT_W; k++) begin
         step_in[k] = sqrt_step(prev[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[ROOT_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= in_side;
         for (int k = 0; k < ROOT_W; k++) begin
            step_ff[k] <= step_in[k];
         end
         for (int k = 1; k < ROOT_W; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = step_ff[ROOT_W-1].root;
   assign out_side  = side_ff[ROOT_W-1];

   // A positive argument is at least one, so the root is at least its scaled value.
   `RMQ_ASSERT_IMPL(a_root_floor, out_valid && !out_side.bad, out_root >= MIN_ROOT)

endmodule

// ----- hdl/rmq_div.sv -----
`include "rotation_matrix_to_quaternion_assert.svh"

module rmq_div (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic                                    in_valid,
   input  rmq_pkg::mag_type [rmq_pkg::LANES-1:0]   in_mag,
   input  rmq_pkg::div_side_type                   in_side,
   output logic                                    out_valid,
   output logic [rmq_pkg::LANES-1:0][rmq_pkg::Q_W-1:0] out_quo,
   output rmq_pkg::div_side_type                   out_side
);
   import rmq_pkg::*;

   logic [Q_W-1:0] valid_ff;
   dv_step_type    step_ff [Q_W][LANES];
   dv_step_type    step_in [Q_W][LANES];
   dv_step_type    prev    [Q_W][LANES];
   div_side_type   side_ff [Q_W];
   div_side_type   prev_side [Q_W];
   logic [NUM_W-1:0] num [LANES];

   always_comb begin
      prev_side[0] = in_side;
      for (int l = 0; l < LANES; l++) begin
         num[l]         = {in_mag[l], {FRAC_BITS{1'b0}}};
         // The quotient fits Q_W bits, so the top numerator bits stay below the divisor.
         prev[0][l].rem = DREM_W'(num[l][NUM_W-1:Q_W]);
         prev[0][l].quo = '0;
         prev[0][l].num = num[l][Q_W-1:0];
      end
      for (int k = 1; k < Q_W; k++) begin
         prev_side[k] = side_ff[k-1];
         for (int l = 0; l < LANES; l++) begin
            prev[k][l] = step_ff[k-1][l];
         end
      end
      for (int k = 0; k < Q_W; k++) begin
         for (int l = 0; l < LANES; l++) begin
            step_in[k][l] = div_step(prev[k][l], {prev_side[k].root, 2'b00});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[Q_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < Q_W; k++) begin
            side_ff[k] <= prev_side[k];
            for (int l = 0; l < LANES; l++) begin
               step_ff[k][l] <= step_in[k][l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quo[l] = step_ff[Q_W-1][l].quo;
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

   // A finished division always leaves a remainder below the divisor.
   `RMQ_ASSERT_IMPL(a_rem_below_divisor, out_valid && !out_side.bad,
      (step_ff[Q_W-1][0].rem < DREM_W'({out_side.root, 2'b00})) &&
      (step_ff[Q_W-1][1].rem < DREM_W'({out_side.root, 2'b00})) &&
      (step_ff[Q_W-1][2].rem < DREM_W'({out_side.root, 2'b00})))

endmodule

// ----- bench/tb_rotation_matrix_to_quaternion.sv -----
`timescale 1ns / 100ps

class quat_scoreboard;
   typedef struct {
      logic signed [15:0] w, x, y, z;
      logic bad;
   } quat_type;

   quat_type pending[$];
   int errors;
   int matched;
   int bad_seen;
   int branch_seen[4];

   function logic signed [15:0] clip(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function longint root_floor(longint n);
      longint r;
      r = 0;
      while ((r + 1) * (r + 1) <= n) r++;
      return r;
   endfunction

   function logic signed [15:0] off_part(longint d, longint p);
      return clip((d * 16384) / (4 * p));
   endfunction

   // Notes one accepted matrix and works out the quaternion it must give.
   function void note_matrix(input logic signed [15:0] m[9]);
      longint r[3][3];
      longint tr, a, p;
      int sel;
      quat_type q;
      for (int i = 0; i < 9; i++) r[i / 3][i % 3] = m[i];
      q = '{0, 0, 0, 0, 0};
      tr = r[0][0] + r[1][1] + r[2][2];
      sel = 0;
      if (r[1][1] > r[0][0]) sel = 1;
      if (r[2][2] > r[sel][sel]) sel = 2;
      if (tr >= 0) sel = 3;
      case (sel)
         3: a = tr + 16384;
         0: a = r[0][0] - r[1][1] - r[2][2] + 16384;
         1: a = r[1][1] - r[2][2] - r[0][0] + 16384;
         default: a = r[2][2] - r[0][0] - r[1][1] + 16384;
      endcase
      if (a <= 0) begin
         q.bad = 1;
      end else begin
         branch_seen[sel]++;
         p = root_floor(a * 4096);
         if (p < 1) p = 1;
         case (sel)
            3: begin
               q.w = clip(p);
               q.x = off_part(r[2][1] - r[1][2], p);
               q.y = off_part(r[0][2] - r[2][0], p);
               q.z = off_part(r[1][0] - r[0][1], p);
            end
            0: begin
               q.x = clip(p);
               q.y = off_part(r[1][0] + r[0][1], p);
               q.z = off_part(r[2][0] + r[0][2], p);
               q.w = off_part(r[2][1] - r[1][2], p);
            end
            1: begin
               q.y = clip(p);
               q.z = off_part(r[2][1] + r[1][2], p);
               q.x = off_part(r[0][1] + r[1][0], p);
               q.w = off_part(r[0][2] - r[2][0], p);
            end
            default: begin
               q.z = clip(p);
               q.x = off_part(r[0][2] + r[2][0], p);
               q.y = off_part(r[1][2] + r[2][1], p);
               q.w = off_part(r[1][0] - r[0][1], p);
            end
         endcase
      end
      if (q.bad) bad_seen++;
      pending.insert(pending.size(), q);
   endfunction

   task report(string msg);
      $display("mismatch %s", msg);
      errors++;
   endtask

   task check_quat(logic signed [15:0] w, x, y, z, logic bad);
      quat_type e;
      if (pending.size() == 0) begin
         report("result word with no matrix outstanding");
         return;
      end
      e = pending.pop_front();
      if (w !== e.w) report($sformatf("q_w: got %0d expected %0d", w, e.w));
      if (x !== e.x) report($sformatf("q_x: got %0d expected %0d", x, e.x));
      if (y !== e.y) report($sformatf("q_y: got %0d expected %0d", y, e.y));
      if (z !== e.z) report($sformatf("q_z: got %0d expected %0d", z, e.z));
      if (bad !== e.bad)
         report($sformatf("bad_matrix: got %0d expected %0d", bad, e.bad));
      matched++;
   endtask
endclass

module tb_rotation_matrix_to_quaternion;
   import rmq_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   data_type req_m[9];
   logic rsp_valid;
   logic rsp_ready = 0;
   data_type rsp_q_w, rsp_q_x, rsp_q_y, rsp_q_z;
   logic rsp_bad_matrix;

   quat_scoreboard sb = new();
   bit hold_off = 0;
   bit sending_done = 0;
   int sent = 0;

   initial for (int i = 0; i < 9; i++) req_m[i] = '0;

   always #1 clock = ~clock;

   rotation_matrix_to_quaternion dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_m00(req_m[0]), .req_m01(req_m[1]), .req_m02(req_m[2]),
      .req_m10(req_m[3]), .req_m11(req_m[4]), .req_m12(req_m[5]),
      .req_m20(req_m[6]), .req_m21(req_m[7]), .req_m22(req_m[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_q_w(rsp_q_w), .rsp_q_x(rsp_q_x), .rsp_q_y(rsp_q_y), .rsp_q_z(rsp_q_z),
      .rsp_bad_matrix(rsp_bad_matrix)
   );

   // Monitor both channels on the edge, before the drivers change anything.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_matrix(req_m);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_quat(rsp_q_w, rsp_q_x, rsp_q_y, rsp_q_z, rsp_bad_matrix);
   end

   // Receiver: a stall pattern of its own, plus a long hold-off on request.
   initial begin
      int phase;
      phase = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) rsp_ready <= 0;
         else if (phase < 300) rsp_ready <= 1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
         phase = (phase + 1) % 900;
         @(posedge clock);
      end
   end

   task automatic send_matrix(input data_type v[9]);
      req_valid <= 1;
      for (int i = 0; i < 9; i++) req_m[i] <= v[i];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic data_type rand_elem();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return data_type'($urandom_range(0, 32767));
         default: return data_type'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // A near-rotation: diagonal picks a branch, off-diagonals are moderate.
   function automatic void make_rotation(output data_type v[9]);
      int big;
      big = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++)
         v[i] = data_type'($signed($urandom_range(0, 32768)) - 16384);
      if (big < 3) begin
         for (int d = 0; d < 3; d++)
            v[d * 4] = data_type'(-$signed($urandom_range(4000, 16384)));
         v[big * 4] = data_type'($urandom_range(0, 16384));
      end
   endfunction

   task automatic directed();
      data_type v[9];
      data_type id[9];
      id = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
      send_matrix(id);
      v = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(v);
      v = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(v);
      v = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(v);
      // Ties on the diagonal go to the lower index.
      v = '{-100, 5, 7, 9, -100, 11, 13, 15, -200}; send_matrix(v);
      v = '{-300, 5, 7, 9, -100, 11, 13, 15, -100}; send_matrix(v);
      // Negative traces from large negative diagonals; the root argument stays positive.
      v = '{-8192, 1, 2, 3, -8192, 4, 5, 6, -16384}; send_matrix(v);
      v = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}; send_matrix(v);
      // Trace zero and extremes, full-scale off-diagonals.
      v = '{0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0}; send_matrix(v);
      v = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
      send_matrix(v);
      v = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
      send_matrix(v);
      v = '{-16384, 32767, 32767, 32767, -16384, -32768, 32767, -32768, -1};
      send_matrix(v);
      v = '{-1, -32768, 32767, -32768, -1, 32767, -32768, 32767, -16384};
      send_matrix(v);
      v = '{-5, 0, 0, 0, -5, 0, 0, 0, 9}; send_matrix(v);
      idle_cycles(1);
   endtask

   initial begin
      data_type v[9];
      int burst;
      bit drained;
      drained = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed();
      for (int n = 0; n < 550; ) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && n < 550; b++, n++) begin
            if ($urandom_range(0, 4) == 0)
               for (int i = 0; i < 9; i++) v[i] = rand_elem();
            else
               make_rotation(v);
            send_matrix(v);
            // Long receiver hold-off while items keep coming.
            if (n == 150) hold_off = 1;
            if (n == 200) hold_off = 0;
         end
         if (n >= 300 && !drained) begin
            drained = 1;
            req_valid <= 0;
            while (sb.pending.size() != 0) @(posedge clock);
         end else if ($urandom_range(0, 2) != 0) begin
            idle_cycles($urandom_range(1, 12));
         end
      end
      req_valid <= 0;
      sending_done = 1;
   end

   // Cap the hold-off even if the sender is stuck behind it.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) begin
            repeat (120) @(posedge clock);
            hold_off = 0;
         end
      end
   end

   initial begin
      wait (sending_done);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Sent %0d matrices: %0d invalid, branches w/x/y/z %0d/%0d/%0d/%0d.",
               sent, sb.bad_seen, sb.branch_seen[3], sb.branch_seen[0],
               sb.branch_seen[1], sb.branch_seen[2]);
      $display("Results checked: %0d, mismatches: %0d.", sb.matched, sb.errors);
      if (sb.errors == 0)
         $display("** rotation_matrix_to_quaternion: PASSED **");
      else
         $display("** rotation_matrix_to_quaternion: FAILED **");
      $finish;
   end

   initial begin
      #200000;
      $display("timeout");
      $display("** rotation_matrix_to_quaternion: FAILED **");
      $finish;
   end
endmodule
